FILE: rtl/oll_pkg.sv
package oll_pkg;

  localparam int OLL_CAPACITY = 32;
  localparam int DW = 32;

  localparam logic [2:0] FN_READ       = 3'd0;
  localparam logic [2:0] FN_INS_HEAD   = 3'd1;
  localparam logic [2:0] FN_INS_TAIL   = 3'd2;
  localparam logic [2:0] FN_INS_BEFORE = 3'd3;
  localparam logic [2:0] FN_INS_AFTER  = 3'd4;
  localparam logic [2:0] FN_DEL_HEAD   = 3'd5;
  localparam logic [2:0] FN_DEL_TAIL   = 3'd6;
  localparam logic [2:0] FN_DEL_KEY    = 3'd7;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

FILE: rtl/ordered_list_engine.sv
// Order: tail delete and refused requests give their result in the cycle after acceptance;
//   tail insert and head insert into an empty list pass through SHUP_RD first. Read out
//   goes through READ_RD and READ_EM, then gives one entry per cycle. A key search adds
//   SCAN_RD and a SCAN_CMP pass per entry visited; each moved entry adds a read and a write pass.
// Throughput: one request at a time; busy is low again when the last result shows.
// Reset: rst (sync) empties the list; the entry memory keeps no reset and needs no sweep.
module ordered_list_engine
  import oll_pkg::*;
#(
  parameter int CAPACITY = OLL_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func,
  input  logic signed [DW-1:0] key,
  input  logic signed [DW-1:0] value,
  output logic                 valid,
  output logic signed [DW-1:0] entry,
  output logic [1:0]           status,
  output logic                 last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    IDLE, READ_RD, READ_EM, SCAN_RD, SCAN_CMP, SHUP_RD, SHUP_WR, SHDN_RD
  } state_t;

  state_t state;
  logic          shdn_wr;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [2:0]    func_r;
  logic [DW-1:0] key_r;
  logic [DW-1:0] value_r;

  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          we;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          empty;
  logic          full;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign empty   = (count == '0);
  assign full    = (count == CW'(CAPACITY));
  assign busy    = (state != IDLE);

  always_comb begin
    raddr = idx[AW-1:0];
    waddr = idx[AW-1:0];
    wdata = rdata;
    we    = 1'b0;
    case (state)
      READ_EM, SCAN_CMP: raddr = idx_inc[AW-1:0];
      SHUP_RD: begin
        raddr = idx_dec[AW-1:0];
        if (idx == pos) begin
          we    = 1'b1;
          wdata = value_r;
        end
      end
      SHUP_WR: we = 1'b1;
      SHDN_RD: begin
        raddr = idx_inc[AW-1:0];
        we    = shdn_wr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count   <= '0;
      idx     <= '0;
      pos     <= '0;
      shdn_wr <= 1'b0;
      valid   <= 1'b0;
      entry   <= '0;
      status  <= ST_DONE;
      last    <= 1'b0;
    end else begin
      valid  <= 1'b0;
      entry  <= '0;
      status <= ST_DONE;
      last   <= 1'b1;
      case (state)
        IDLE: begin
          if (start) begin
            func_r  <= func;
            key_r   <= key;
            value_r <= value;
            idx     <= '0;
            shdn_wr <= 1'b0;
            case (func)
              FN_READ: begin
                if (empty) begin
                  valid  <= 1'b1;
                  status <= ST_ABSENT;
                end else begin
                  state <= READ_RD;
                end
              end
              FN_INS_HEAD, FN_INS_TAIL: begin
                if (full) begin
                  valid  <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  idx   <= count;
                  pos   <= (func == FN_INS_HEAD) ? '0 : count;
                  state <= SHUP_RD;
                end
              end
              FN_INS_BEFORE, FN_INS_AFTER: begin
                if (full || empty) begin
                  valid  <= 1'b1;
                  status <= full ? ST_FULL : ST_ABSENT;
                end else begin
                  state <= SCAN_RD;
                end
              end
              FN_DEL_HEAD: begin
                if (empty) begin
                  valid  <= 1'b1;
                  status <= ST_ABSENT;
                end else begin
                  state <= SHDN_RD;
                end
              end
              FN_DEL_TAIL: begin
                valid <= 1'b1;
                if (empty) begin
                  status <= ST_ABSENT;
                end else begin
                  count <= count - CW'(1);
                end
              end
              FN_DEL_KEY: begin
                if (empty) begin
                  valid  <= 1'b1;
                  status <= ST_ABSENT;
                end else begin
                  state <= SCAN_RD;
                end
              end
              default: begin
                valid  <= 1'b1;
                status <= ST_ABSENT;
              end
            endcase
          end
        end
        READ_RD: state <= READ_EM;
        READ_EM: begin
          valid <= 1'b1;
          entry <= rdata;
          last  <= (idx_inc == count);
          idx   <= idx_inc;
          if (idx_inc == count) begin
            state <= IDLE;
          end
        end
        SCAN_RD: state <= SCAN_CMP;
        SCAN_CMP: begin
          if (rdata == key_r) begin
            if (func_r == FN_DEL_KEY) begin
              state <= SHDN_RD;
            end else begin
              pos   <= (func_r == FN_INS_AFTER) ? idx_inc : idx;
              idx   <= count;
              state <= SHUP_RD;
            end
          end else if (idx_inc == count) begin
            valid  <= 1'b1;
            status <= ST_ABSENT;
            state  <= IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        SHUP_RD: begin
          if (idx == pos) begin
            count <= count + CW'(1);
            valid <= 1'b1;
            state <= IDLE;
          end else begin
            state <= SHUP_WR;
          end
        end
        SHUP_WR: begin
          idx   <= idx_dec;
          state <= SHUP_RD;
        end
        SHDN_RD: begin
          // shdn_wr: rdata holds entry idx+1 read in the previous pass
          if (shdn_wr) begin
            shdn_wr <= 1'b0;
            idx     <= idx_inc;
          end else if (idx_inc == count) begin
            count <= count - CW'(1);
            valid <= 1'b1;
            state <= IDLE;
          end else begin
            shdn_wr <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/oll_checker.sv
module oll_checker
  import oll_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          valid,
  input logic [DW-1:0] entry,
  input logic [1:0]    status,
  input logic          last
);

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && status != ST_DONE |-> last && entry == '0)
    else $error("failed request result not final or carries data");

  a_readout_runs: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("read out stream broken");

  a_readout_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("new request possible in the middle of a read out");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !valid && !busy)
    else $error("activity right after reset");

endmodule

bind ordered_list_engine oll_checker u_oll_checker (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .valid(valid),
  .entry(entry),
  .status(status),
  .last(last)
);

FILE: tb/sv/ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_tb;
  import oll_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_HOLD = 200;
  localparam int SEG_FILL = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIX = 2;
  localparam logic signed [DW-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [DW-1:0] MAX_VAL = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] ALT_VAL = 32'sh2aaa_aaaa;

  typedef struct packed {
    logic signed [DW-1:0] entry;
    logic [1:0]           status;
    logic                 last;
  } list_result_t;

  typedef struct {
    logic [2:0]           func;
    logic signed [DW-1:0] key;
    logic signed [DW-1:0] value;
    bit                   typed;
    logic [1:0]           status;
  } list_cmd_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [2:0]           func;
  logic signed [DW-1:0] key;
  logic signed [DW-1:0] value;
  logic                 valid;
  logic signed [DW-1:0] entry;
  logic [1:0]           status;
  logic                 last;

  logic signed [DW-1:0] list_model[$];
  list_result_t         pending_results[$];
  list_result_t         exp_r;
  list_cmd_t            directed_cmds[23];
  int                   fail_cnt;
  int                   stall_cycles;
  bit                   quiet;

  ordered_list_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .key(key),
    .value(value),
    .valid(valid),
    .entry(entry),
    .status(status),
    .last(last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts the results of one request and updates the list copy.
  task automatic apply_list_command(input logic [2:0] f, input logic signed [DW-1:0] k,
                                    input logic signed [DW-1:0] v);
    int pos;
    bit full;
    logic [1:0] st;
    pos = -1;
    st = ST_DONE;
    full = list_model.size() >= OLL_CAPACITY;
    foreach (list_model[i]) if (pos < 0 && list_model[i] == k) pos = i;
    if (f == FN_READ) begin
      if (list_model.size() == 0) begin
        pending_results.push_back('{entry: '0, status: ST_ABSENT, last: 1'b1});
      end else begin
        foreach (list_model[i])
          pending_results.push_back('{entry: list_model[i], status: ST_DONE,
                                      last: (i == list_model.size() - 1)});
      end
    end else begin
      case (f)
        FN_INS_HEAD: begin
          if (full) st = ST_FULL;
          else list_model.push_front(v);
        end
        FN_INS_TAIL: begin
          if (full) st = ST_FULL;
          else list_model.push_back(v);
        end
        FN_INS_BEFORE, FN_INS_AFTER: begin
          if (full) st = ST_FULL;
          else if (pos < 0) st = ST_ABSENT;
          else list_model.insert((f == FN_INS_BEFORE) ? pos : pos + 1, v);
        end
        FN_DEL_HEAD: begin
          if (list_model.size() == 0) st = ST_ABSENT;
          else void'(list_model.pop_front());
        end
        FN_DEL_TAIL: begin
          if (list_model.size() == 0) st = ST_ABSENT;
          else void'(list_model.pop_back());
        end
        default: begin
          if (pos < 0) st = ST_ABSENT;
          else list_model.delete(pos);
        end
      endcase
      pending_results.push_back('{entry: '0, status: st, last: 1'b1});
    end
  endtask

  task automatic send_request(input logic [2:0] f, input logic signed [DW-1:0] k,
                              input logic signed [DW-1:0] v);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 29) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    key <= k;
    value <= v;
    do @(posedge clk); while (busy);
    apply_list_command(f, k, v);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_segment(input int mode, input int n);
    int roll;
    logic [2:0] f;
    logic signed [DW-1:0] k;
    logic signed [DW-1:0] v;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      case (mode)
        SEG_FILL:
          f = (roll < 85) ? 3'($urandom_range(1, 4)) :
              (roll < 90) ? FN_READ : 3'($urandom_range(5, 7));
        SEG_DRAIN:
          f = (roll < 80) ? 3'($urandom_range(5, 7)) :
              (roll < 88) ? FN_READ : 3'($urandom_range(1, 4));
        default:
          f = 3'($urandom_range(0, 7));
      endcase
      if (list_model.size() > 0 && $urandom_range(0, 99) < 80)
        k = list_model[$urandom_range(0, list_model.size() - 1)];
      else if ($urandom_range(0, 3) == 0)
        k = 32'($urandom_range(0, 15)) - 32'sd8;
      else
        k = $urandom;
      if ($urandom_range(0, 1) == 0) v = $urandom;
      else v = 32'($urandom_range(0, 15)) - 32'sd8;
      send_request(f, k, v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result entry=%0d status=%0d last=%0d",
                 $time, entry, status, last);
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (entry !== exp_r.entry) begin
          $display("%0t: entry mismatch exp=%0d got=%0d", $time, exp_r.entry, entry);
          fail_cnt++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status mismatch exp=%0d got=%0d", $time, exp_r.status, status);
          fail_cnt++;
        end
        if (last !== exp_r.last) begin
          $display("%0t: last mismatch exp=%0d got=%0d", $time, exp_r.last, last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    fail_cnt = 0;
    stall_cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    func = FN_READ;
    key = '0;
    value = '0;
    directed_cmds = '{
      '{FN_READ,       '0,        '0,      1'b1, ST_ABSENT},
      '{FN_DEL_HEAD,   '0,        '0,      1'b1, ST_ABSENT},
      '{FN_DEL_TAIL,   '0,        '0,      1'b1, ST_ABSENT},
      '{FN_DEL_KEY,    '0,        '0,      1'b1, ST_ABSENT},
      '{FN_INS_BEFORE, '0,        '0,      1'b1, ST_ABSENT},
      '{FN_INS_AFTER,  -32'sd1,   '0,      1'b1, ST_ABSENT},
      '{FN_INS_HEAD,   '0,        MIN_VAL, 1'b1, ST_DONE},
      '{FN_INS_TAIL,   '0,        MAX_VAL, 1'b1, ST_DONE},
      '{FN_INS_AFTER,  MIN_VAL,   -32'sd1, 1'b1, ST_DONE},
      '{FN_INS_BEFORE, MAX_VAL,   '0,      1'b1, ST_DONE},
      '{FN_INS_HEAD,   '0,        MAX_VAL, 1'b1, ST_DONE},
      '{FN_READ,       '0,        '0,      1'b0, ST_DONE},
      '{FN_DEL_KEY,    MAX_VAL,   '0,      1'b1, ST_DONE},
      '{FN_INS_AFTER,  32'sd12345, ALT_VAL, 1'b1, ST_ABSENT},
      '{FN_DEL_KEY,    ~ALT_VAL,  '0,      1'b1, ST_ABSENT},
      '{FN_INS_BEFORE, -32'sd1,   ALT_VAL, 1'b0, ST_DONE},
      '{FN_READ,       '0,        '0,      1'b0, ST_DONE},
      '{FN_DEL_HEAD,   '0,        '0,      1'b1, ST_DONE},
      '{FN_DEL_TAIL,   '0,        '0,      1'b1, ST_DONE},
      '{FN_INS_TAIL,   '0,        '0,      1'b1, ST_DONE},
      '{FN_INS_AFTER,  '0,        32'sd5,  1'b0, ST_DONE},
      '{FN_DEL_KEY,    '0,        '0,      1'b0, ST_DONE},
      '{FN_READ,       '0,        '0,      1'b0, ST_DONE}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cmds[i]) begin
      send_request(directed_cmds[i].func, directed_cmds[i].key, directed_cmds[i].value);
      if (directed_cmds[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back('{entry: '0, status: directed_cmds[i].status,
                                    last: 1'b1});
      end
    end
    wait_results_drained();

    run_segment(SEG_FILL, 50);
    wait_results_drained();
    quiet = 1'b1;
    run_segment(SEG_MIX, 25);
    quiet = 1'b0;
    run_segment(SEG_DRAIN, 45);
    wait_results_drained();
    run_segment(SEG_FILL, 45);
    run_segment(SEG_MIX, 22);

    wait_results_drained();
    repeat (DRAIN_HOLD) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: ordered_list_engine.f
rtl/oll_pkg.sv
rtl/ordered_list_engine.sv
rtl/oll_checker.sv
tb/sv/ordered_list_engine_tb.sv
